// ----- rtl/bplr_pkg.sv -----
// Package: shared constants and types of the button press detector.
`default_nettype none
package bplr_pkg;

  localparam int BUTTONS    = 4;
  localparam int BTN_W      = $clog2(BUTTONS);
  localparam int CODE_W     = BTN_W + 1;
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int FILT_W = 7;
  localparam int LONG_W = 12;
  localparam int REP_W  = 8;
  localparam int DC_W   = FILT_W + 1;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 12;

  localparam logic [CFG_IW-1:0] REG_FILTER = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LONG   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_REPEAT = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  localparam logic [FILT_W-1:0] FILTER_RST = 7'd5;
  localparam logic [LONG_W-1:0] LONG_RST   = 12'd100;
  localparam logic [REP_W-1:0]  REPEAT_RST = 8'd0;

  typedef struct packed {
    logic [FILT_W-1:0] filter_ticks;
    logic [LONG_W-1:0] long_ticks;
    logic [REP_W-1:0]  repeat_period;
  } cfg_t;

  typedef struct packed {
    logic req;
    logic kind;
  } push_t;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
    logic [BUTTONS-1:0] pressed_flags;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/bplr_ifs.sv -----
// Interfaces: input, result and configuration channels.
`default_nettype none
interface bplr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bplr_pkg::BUTTONS-1:0] button_levels;
  modport source (output valid, output op, output button_levels, input ready);
  modport sink (input valid, input op, input button_levels, output ready);
endinterface

interface bplr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         key_valid;
  logic [bplr_pkg::CODE_W-1:0]  key_code;
  logic [bplr_pkg::BUTTONS-1:0] pressed_flags;
  modport source (output valid, output key_valid, output key_code, output pressed_flags,
                  input ready);
  modport sink (input valid, input key_valid, input key_code, input pressed_flags,
                output ready);
endinterface

interface bplr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bplr_pkg::CFG_IW-1:0] index;
  logic [bplr_pkg::CFG_DW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/bplr_lane.sv -----
// Lane: debounce, long-press and repeat tracking of one button.
`default_nettype none
module bplr_lane (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tick_en,
  input  wire logic           level,
  input  wire bplr_pkg::cfg_t cfg,
  output bplr_pkg::push_t     push,
  output logic                pressed_after
);

  logic [bplr_pkg::DC_W-1:0]   debounce_count, debounce_count_next;
  logic                        pressed, pressed_next;
  logic [bplr_pkg::LONG_W-1:0] hold_count, hold_count_next;
  logic [bplr_pkg::REP_W-1:0]  repeat_count, repeat_count_next;

  logic [bplr_pkg::DC_W-1:0]   filt_ext;
  logic [bplr_pkg::DC_W-1:0]   filt_dbl;
  logic [bplr_pkg::LONG_W-1:0] hold_inc;
  logic [bplr_pkg::REP_W:0]    rep_inc;
  logic                        long_en;
  logic                        hold_lt;

  assign filt_ext = {1'b0, cfg.filter_ticks};
  assign filt_dbl = {cfg.filter_ticks, 1'b0};
  assign hold_inc = hold_count + 1'b1;
  assign rep_inc  = {1'b0, repeat_count} + 1'b1;
  assign long_en  = cfg.long_ticks != '0;
  assign hold_lt  = hold_count < cfg.long_ticks;

  always_comb begin
    debounce_count_next = debounce_count;
    pressed_next        = pressed;
    hold_count_next     = hold_count;
    repeat_count_next   = repeat_count;
    push.req            = 1'b0;
    push.kind           = bplr_pkg::KIND_SHORT;
    if (level) begin
      if (debounce_count < filt_ext) begin
        debounce_count_next = filt_ext;
      end else if (debounce_count < filt_dbl) begin
        debounce_count_next = debounce_count + 1'b1;
      end else begin
        pressed_next = 1'b1;
        if (long_en) begin
          if (hold_lt) begin
            hold_count_next = hold_inc;
            if (hold_inc == cfg.long_ticks) begin
              push.req  = 1'b1;
              push.kind = bplr_pkg::KIND_LONG;
            end
          end else if (cfg.repeat_period != '0) begin
            repeat_count_next = rep_inc[bplr_pkg::REP_W-1:0];
            if (rep_inc >= {1'b0, cfg.repeat_period}) begin
              repeat_count_next = '0;
              push.req          = 1'b1;
            end
          end
        end
      end
    end else if (debounce_count != '0) begin
      if (pressed) begin
        pressed_next = 1'b0;
        push.req     = !long_en || hold_lt;
      end
      hold_count_next     = '0;
      repeat_count_next   = '0;
      debounce_count_next = '0;
    end
  end

  assign pressed_after = tick_en ? pressed_next : pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= '0;
      pressed        <= 1'b0;
      hold_count     <= '0;
      repeat_count   <= '0;
    end else if (tick_en) begin
      debounce_count <= debounce_count_next;
      pressed        <= pressed_next;
      hold_count     <= hold_count_next;
      repeat_count   <= repeat_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bplr_ring.sv -----
// Merge stage: orders lane pushes into the key code ring and serves reads.
`default_nettype none
module bplr_ring (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tick_en,
  input  wire logic                        read_en,
  input  wire bplr_pkg::push_t             push [bplr_pkg::BUTTONS],
  output logic                             key_valid,
  output logic [bplr_pkg::CODE_W-1:0]      key_code
);

  logic [bplr_pkg::CODE_W-1:0]  ring [bplr_pkg::RING_DEPTH];
  logic [bplr_pkg::RING_AW-1:0] ring_read_pos;
  logic [bplr_pkg::RING_AW-1:0] ring_write_pos, ring_write_pos_next;
  logic [bplr_pkg::RING_AW-1:0] slot [bplr_pkg::BUTTONS];

  // place each push after those of lower buttons
  always_comb begin
    ring_write_pos_next = ring_write_pos;
    for (int k = 0; k < bplr_pkg::BUTTONS; k++) begin
      slot[k] = ring_write_pos_next;
      if (push[k].req) begin
        ring_write_pos_next = ring_write_pos_next + 1'b1;
      end
    end
  end

  assign key_valid = ring_read_pos != ring_write_pos;
  assign key_code  = key_valid ? ring[ring_read_pos] : '0;

  always_ff @(posedge clk) begin
    if (tick_en) begin
      for (int k = 0; k < bplr_pkg::BUTTONS; k++) begin
        if (push[k].req) begin
          ring[slot[k]] <= {bplr_pkg::BTN_W'(k), push[k].kind};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_read_pos  <= '0;
      ring_write_pos <= '0;
    end else begin
      if (tick_en) begin
        ring_write_pos <= ring_write_pos_next;
      end
      if (read_en && key_valid) begin
        ring_read_pos <= ring_read_pos + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bplr_out_buf.sv -----
// Output buffer: result register with a skid word.
`default_nettype none
module bplr_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bplr_pkg::result_t din,
  output logic                   can_take,
  output logic                   dout_valid,
  input  wire logic              dout_ready,
  output bplr_pkg::result_t      dout
);

  bplr_pkg::result_t skid;
  logic              skid_valid;
  logic              advance;

  assign can_take = !skid_valid;
  assign advance  = dout_ready || !dout_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      dout <= skid_valid ? skid : din;
    end else if (push) begin
      skid <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      dout_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/button_press_long_repeat_detector_core.sv -----
// Top level: four button lanes, key code ring and result buffer.
// Each accepted item yields one result word, registered in the result buffer.
// Throughput: one item per cycle while the buffer can take it; lanes and ring update in the accept cycle.
// A two-word result buffer keeps input open while one result waits.
// Reset: synchronous, clears lane counters, pressed flags, ring positions and
// result valid; registers return to filter 5, long 100, repeat 0.
`default_nettype none
module button_press_long_repeat_detector_core (
  input  wire logic   clk,
  input  wire logic   rst,
  bplr_in_if.sink     in,
  bplr_out_if.source  out,
  bplr_cfg_if.sink    cfg
);

  bplr_pkg::cfg_t    cfg_regs;
  bplr_pkg::push_t   push [bplr_pkg::BUTTONS];
  bplr_pkg::result_t result;
  bplr_pkg::result_t dout;
  logic [bplr_pkg::BUTTONS-1:0] flags;
  logic ring_valid;
  logic [bplr_pkg::CODE_W-1:0] ring_code;
  logic accept;
  logic tick_en;
  logic read_en;
  logic can_take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.filter_ticks  <= bplr_pkg::FILTER_RST;
      cfg_regs.long_ticks    <= bplr_pkg::LONG_RST;
      cfg_regs.repeat_period <= bplr_pkg::REPEAT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        bplr_pkg::REG_FILTER: cfg_regs.filter_ticks  <= cfg.data[bplr_pkg::FILT_W-1:0];
        bplr_pkg::REG_LONG:   cfg_regs.long_ticks    <= cfg.data[bplr_pkg::LONG_W-1:0];
        bplr_pkg::REG_REPEAT: cfg_regs.repeat_period <= cfg.data[bplr_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in.ready = can_take;
  assign accept   = in.valid && can_take;
  assign tick_en  = accept && (in.op == bplr_pkg::OP_TICK);
  assign read_en  = accept && (in.op == bplr_pkg::OP_READ);

  for (genvar b = 0; b < bplr_pkg::BUTTONS; b++) begin : g_lane
    bplr_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .tick_en      (tick_en),
      .level        (in.button_levels[b]),
      .cfg          (cfg_regs),
      .push         (push[b]),
      .pressed_after(flags[b])
    );
  end

  bplr_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .tick_en  (tick_en),
    .read_en  (read_en),
    .push     (push),
    .key_valid(ring_valid),
    .key_code (ring_code)
  );

  always_comb begin
    result.pressed_flags = flags;
    result.key_valid     = 1'b0;
    result.key_code      = '0;
    if (in.op == bplr_pkg::OP_READ) begin
      result.key_valid = ring_valid;
      result.key_code  = ring_code;
    end
  end

  bplr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (result),
    .can_take  (can_take),
    .dout_valid(out.valid),
    .dout_ready(out.ready),
    .dout      (dout)
  );

  assign out.key_valid     = dout.key_valid;
  assign out.key_code      = dout.key_code;
  assign out.pressed_flags = dout.pressed_flags;

endmodule
`default_nettype wire

// ----- rtl/bplr_checker.sv -----
// Checker: port-level properties of the detector, bound to the top level.
`default_nettype none
module bplr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         key_valid,
  input wire logic [bplr_pkg::CODE_W-1:0]  key_code,
  input wire logic [bplr_pkg::BUTTONS-1:0] pressed_flags
);

  a_empty_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_code == '0)
    else $error("key code nonzero without key valid");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_valid) && $stable(key_code)
      && $stable(pressed_flags))
    else $error("result word changed while stalled");

  a_busy_has_word: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending after reset");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind button_press_long_repeat_detector_core bplr_checker u_bplr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in.valid),
  .in_ready     (in.ready),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .key_valid    (out.key_valid),
  .key_code     (out.key_code),
  .pressed_flags(out.pressed_flags)
);
`default_nettype wire
